[src/gbn_pkg.sv]
// Shared types and constants for the go-back-n sender window.
package gbn_pkg;

    localparam int SEQ_W        = 32;
    localparam int LEN_W        = 11;
    localparam int WINDOW_DEPTH = 16;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int MAX_PAYLOAD  = 1024;
    localparam int MAX_RESULTS  = 16;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        KIND_NEW      = 3'd0,
        KIND_RETX     = 3'd1,
        KIND_FULL     = 3'd2,
        KIND_FINISHED = 3'd3,
        KIND_ACK_OK   = 3'd4,
        KIND_ACK_BAD  = 3'd5
    } t_kind;

    typedef enum logic {
        B_IDLE,
        B_RETX
    } t_back_state;

    typedef struct packed {
        t_op               op;
        logic              empty_end;
        logic [LEN_W-1:0]  length;
        logic [SEQ_W-1:0]  ack_number;
        logic              ack_pre_ok;
    } t_item;

    typedef struct packed {
        t_kind             kind;
        logic [SEQ_W-1:0]  seq;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  length;
        logic              last;
        logic              finished;
    } t_result;

endpackage

[src/gbn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/gbn_front.sv]
// Front end: connection register, input acceptance and item classification.
module gbn_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_operation,
    input  logic [gbn_pkg::LEN_W-1:0]   i_payload_length,
    input  logic                        i_at_end,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_ack_number,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_ack_connection,
    input  logic                        i_ack_flag_set,
    input  logic                        i_checksum_good,
    input  logic                        i_queue_full,
    output logic                        o_push,
    output gbn_pkg::t_item              o_item
);
    import gbn_pkg::*;

    logic [SEQ_W-1:0] r_conn_key;
    logic             known_op;
    logic [LEN_W-1:0] sat_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn_key <= '0;
        end else if (i_cfg_wr_en) begin
            r_conn_key <= i_cfg_wr_data;
        end
    end

    always_comb begin
        unique case (i_operation) inside
            OP_SEND, OP_ACK, OP_TIMEOUT: known_op = 1'b1;
            default:                     known_op = 1'b0;
        endcase
    end

    always_comb begin
        if (32'(i_payload_length) > 32'(MAX_PAYLOAD)) begin
            sat_length = LEN_W'(MAX_PAYLOAD);
        end else begin
            sat_length = i_payload_length;
        end
    end

    always_comb begin
        o_item.op         = t_op'(i_operation);
        o_item.empty_end  = (i_payload_length == '0) && i_at_end;
        o_item.length     = sat_length;
        o_item.ack_number = i_ack_number;
        o_item.ack_pre_ok = i_checksum_good && i_ack_flag_set &&
                            (i_ack_connection == r_conn_key);
    end

    // drop unknown operations at acceptance
    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full && known_op;

endmodule

[src/gbn_fifo.sv]
// Short item queue between the front end and the window back end.
module gbn_fifo #(
    parameter int DEPTH = gbn_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gbn_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output gbn_pkg::t_item o_item,
    input  logic           i_pop
);
    import gbn_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(DEPTH);

    t_item             r_entries [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_entries[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_item;
        end
    end

endmodule

[src/gbn_back.sv]
// Back end: window state, slot length memory, retransmit sequencer and output stages.
module gbn_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  gbn_pkg::t_item   i_q_item,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output gbn_pkg::t_result o_result
);
    import gbn_pkg::*;

    t_back_state       r_state, n_state;
    logic [SEQ_W-1:0]  r_base, n_base;
    logic [SEQ_W-1:0]  r_next, n_next;
    logic              r_input_done, n_input_done;
    logic [SEQ_W-1:0]  r_rt_seq, n_rt_seq;
    logic [CNT_W-1:0]  r_rt_left, n_rt_left;

    logic              r_pend_valid;
    logic              r_pend_from_ram;
    t_result           r_pend;
    logic              r_out_valid;
    t_result           r_out;

    logic              pend_move;
    logic              can_issue;
    logic              issue;
    logic              issue_ram;
    t_result           issue_res;
    t_result           pend_final;

    logic [SEQ_W:0]    window_end;
    logic              is_full;
    logic              outstanding;
    logic [SEQ_W-1:0]  span;
    logic [CNT_W-1:0]  rt_count;
    logic              ack_ok;

    logic              wr_en;
    logic              rd_en;
    logic [LEN_W-1:0]  rd_data;

    gbn_ram #(
        .WIDTH (LEN_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_next[SLOT_W-1:0]),
        .i_wr_data (i_q_item.length),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rt_seq[SLOT_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign pend_move = r_pend_valid && (!r_out_valid || !i_stall);
    assign can_issue = !r_pend_valid || pend_move;

    assign window_end  = {1'b0, r_base} + (SEQ_W+1)'(WINDOW_DEPTH);
    assign is_full     = {1'b0, r_next} >= window_end;
    assign outstanding = r_next > r_base;
    assign span        = r_next - r_base;
    assign rt_count    = (span > SEQ_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
                                                      : span[CNT_W-1:0];
    assign ack_ok      = i_q_item.ack_pre_ok && (i_q_item.ack_number >= r_base) &&
                         (i_q_item.ack_number < r_next);

    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_next       = r_next;
        n_input_done = r_input_done;
        n_rt_seq     = r_rt_seq;
        n_rt_left    = r_rt_left;
        issue        = 1'b0;
        issue_ram    = 1'b0;
        issue_res    = '0;
        o_q_pop      = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid && can_issue) begin
                    unique case (i_q_item.op)
                        OP_SEND: begin
                            o_q_pop            = 1'b1;
                            issue              = 1'b1;
                            issue_res.seq      = r_next;
                            issue_res.slot     = r_next[SLOT_W-1:0];
                            issue_res.last     = 1'b1;
                            issue_res.finished = r_input_done;
                            if (is_full) begin
                                issue_res.kind = KIND_FULL;
                            end else if (i_q_item.empty_end) begin
                                n_input_done       = 1'b1;
                                issue_res.kind     = KIND_FINISHED;
                                issue_res.finished = 1'b1;
                            end else begin
                                wr_en            = 1'b1;
                                n_next           = r_next + 1'b1;
                                issue_res.kind   = KIND_NEW;
                                issue_res.length = i_q_item.length;
                            end
                        end
                        OP_ACK: begin
                            o_q_pop            = 1'b1;
                            issue              = 1'b1;
                            issue_res.kind     = ack_ok ? KIND_ACK_OK : KIND_ACK_BAD;
                            issue_res.seq      = i_q_item.ack_number;
                            issue_res.last     = 1'b1;
                            issue_res.finished = r_input_done;
                            if (ack_ok) begin
                                n_base = i_q_item.ack_number + 1'b1;
                            end
                        end
                        OP_TIMEOUT: begin
                            if (outstanding) begin
                                n_state   = B_RETX;
                                n_rt_seq  = r_base;
                                n_rt_left = rt_count;
                            end else begin
                                o_q_pop = 1'b1;
                            end
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            B_RETX: begin
                if (can_issue) begin
                    rd_en              = 1'b1;
                    issue              = 1'b1;
                    issue_ram          = 1'b1;
                    issue_res.kind     = KIND_RETX;
                    issue_res.seq      = r_rt_seq;
                    issue_res.slot     = r_rt_seq[SLOT_W-1:0];
                    issue_res.last     = (r_rt_left == CNT_W'(1));
                    issue_res.finished = r_input_done;
                    n_rt_seq           = r_rt_seq + 1'b1;
                    n_rt_left          = r_rt_left - 1'b1;
                    if (r_rt_left == CNT_W'(1)) begin
                        o_q_pop = 1'b1;
                        n_state = B_IDLE;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_next       <= '0;
            r_input_done <= 1'b0;
            r_rt_left    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_base       <= n_base;
            r_next       <= n_next;
            r_input_done <= n_input_done;
            r_rt_left    <= n_rt_left;
            if (can_issue) begin
                r_pend_valid <= issue;
            end
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= r_pend_valid;
            end
        end
    end

    always_comb begin
        pend_final = r_pend;
        if (r_pend_from_ram) begin
            pend_final.length = rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rt_seq <= n_rt_seq;
        if (can_issue && issue) begin
            r_pend          <= issue_res;
            r_pend_from_ram <= issue_ram;
        end
        if (pend_move) begin
            r_out <= pend_final;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[src/go_back_n_sender_window.sv]
// Go-back-n sender window top level: front end, item queue and window back end.
// An accepted item passes the item queue, then the pending and output registers of the
// back end; a timeout first puts the back end into its retransmit state.
// Throughput: one send or ack item per cycle unless the output stalls; a timeout with N
// outstanding packets (N at most 16) holds the back end for N results, one slot read each.
// Reset is synchronous: base, next sequence, finished flag and connection id clear to zero;
// the slot length memory is not cleared and holds whatever was last written.
module go_back_n_sender_window #(
    parameter int QUEUE_DEPTH = gbn_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_operation,
    input  logic [gbn_pkg::LEN_W-1:0]   i_payload_length,
    input  logic                        i_at_end,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_ack_number,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_ack_connection,
    input  logic                        i_ack_flag_set,
    input  logic                        i_checksum_good,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_kind,
    output logic [gbn_pkg::SEQ_W-1:0]   o_seq_number,
    output logic [gbn_pkg::SLOT_W-1:0]  o_slot,
    output logic [gbn_pkg::LEN_W-1:0]   o_packet_length,
    output logic                        o_last,
    output logic                        o_finished_flag
);
    import gbn_pkg::*;

    logic    q_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    t_item   push_item;
    t_item   head_item;
    t_result result;

    gbn_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_payload_length (i_payload_length),
        .i_at_end         (i_at_end),
        .i_ack_number     (i_ack_number),
        .i_ack_connection (i_ack_connection),
        .i_ack_flag_set   (i_ack_flag_set),
        .i_checksum_good  (i_checksum_good),
        .i_queue_full     (q_full),
        .o_push           (q_push),
        .o_item           (push_item)
    );

    gbn_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item),
        .i_pop   (q_pop)
    );

    gbn_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_item (head_item),
        .o_q_pop  (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (result)
    );

    assign o_kind          = result.kind;
    assign o_seq_number    = result.seq;
    assign o_slot          = result.slot;
    assign o_packet_length = result.length;
    assign o_last          = result.last;
    assign o_finished_flag = result.finished;

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_unknown_op_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_operation != OP_SEND && i_operation != OP_ACK &&
         i_operation != OP_TIMEOUT) |-> !q_push)
        else $error("unknown operation entered the queue");

    a_ack_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_ACK_OK || o_kind == KIND_ACK_BAD)) |->
        (o_slot == '0 && o_packet_length == '0 && o_last))
        else $error("ack result carries slot or length or is not last");

    a_single_results_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_NEW || o_kind == KIND_FULL ||
         o_kind == KIND_FINISHED)) |-> (o_last && o_slot == o_seq_number[SLOT_W-1:0]))
        else $error("send result not last or slot mismatch");

endmodule

[verif/go_back_n_checker.sv]
// Checker for the go-back-n sender window: tracks the window, predicts each result and compares.
module go_back_n_checker
    import gbn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [SEQ_W-1:0]  i_cfg_wr_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_operation,
    input  logic [LEN_W-1:0]  i_payload_length,
    input  logic              i_at_end,
    input  logic [SEQ_W-1:0]  i_ack_number,
    input  logic [SEQ_W-1:0]  i_ack_connection,
    input  logic              i_ack_flag_set,
    input  logic              i_checksum_good,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [2:0]        i_kind,
    input  logic [SEQ_W-1:0]  i_seq_number,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [LEN_W-1:0]  i_packet_length,
    input  logic              i_last,
    input  logic              i_finished_flag,
    output int                o_fail_count,
    output int                o_pending,
    output logic [SEQ_W-1:0]  o_window_base,
    output logic [SEQ_W-1:0]  o_seq_next
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [SEQ_W-1:0] conn_key;
    logic [SEQ_W-1:0] window_base;
    logic [SEQ_W-1:0] seq_next;
    logic [LEN_W-1:0] slot_len [WINDOW_DEPTH];
    logic             input_done;
    t_result          due_results [$];
    int               fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic bit field_differs(input string field, input logic [SEQ_W-1:0] want,
                                         input logic [SEQ_W-1:0] got);
        if (want === got) begin
            return 1'b0;
        end
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : track_window
        t_result          want;
        t_result          note;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seq;
        int               count;
        bit               bad;
        if (!i_rst_n) begin
            conn_key    = '0;
            window_base = '0;
            seq_next    = '0;
            input_done  = 1'b0;
            foreach (slot_len[i]) slot_len[i] = '0;
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d seq %0h",
                             $time, i_kind, i_seq_number);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    bad  = 1'b0;
                    bad |= field_differs("kind", want.kind, i_kind);
                    bad |= field_differs("seq_number", want.seq, i_seq_number);
                    bad |= field_differs("slot", want.slot, i_slot);
                    bad |= field_differs("packet_length", want.length, i_packet_length);
                    bad |= field_differs("last", want.last, i_last);
                    bad |= field_differs("finished_flag", want.finished, i_finished_flag);
                    if (bad) begin
                        fail_count++;
                    end
                end
            end
            if (i_cfg_wr_en) begin
                conn_key = i_cfg_wr_data;
            end
            if (i_in_valid && !i_in_stall) begin
                seq  = seq_next;
                note = '0;
                case (i_operation)
                    OP_SEND: begin
                        note.seq  = seq;
                        note.slot = seq[SLOT_W-1:0];
                        note.last = 1'b1;
                        if ({1'b0, seq} >= {1'b0, window_base} + WINDOW_DEPTH) begin
                            note.kind = KIND_FULL;
                        end else if (i_payload_length == '0 && i_at_end) begin
                            input_done = 1'b1;
                            note.kind  = KIND_FINISHED;
                        end else begin
                            len = (i_payload_length > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD)
                                                                   : i_payload_length;
                            slot_len[seq[SLOT_W-1:0]] = len;
                            seq_next    = seq + 1'b1;
                            note.kind   = KIND_NEW;
                            note.length = len;
                        end
                        note.finished = input_done;
                        due_results.push_back(note);
                    end
                    OP_ACK: begin
                        note.seq  = i_ack_number;
                        note.last = 1'b1;
                        if (i_checksum_good && i_ack_connection == conn_key &&
                            i_ack_flag_set && i_ack_number >= window_base &&
                            i_ack_number < seq_next) begin
                            note.kind   = KIND_ACK_OK;
                            window_base = i_ack_number + 1'b1;
                        end else begin
                            note.kind = KIND_ACK_BAD;
                        end
                        note.finished = input_done;
                        due_results.push_back(note);
                    end
                    OP_TIMEOUT: begin
                        if (seq_next > window_base) begin
                            count = (seq_next - window_base > MAX_RESULTS) ? MAX_RESULTS
                                    : int'(seq_next - window_base);
                            for (int i = 0; i < count; i++) begin
                                seq           = window_base + i;
                                note.kind     = KIND_RETX;
                                note.seq      = seq;
                                note.slot     = seq[SLOT_W-1:0];
                                note.length   = slot_len[seq[SLOT_W-1:0]];
                                note.last     = (i == count - 1);
                                note.finished = input_done;
                                due_results.push_back(note);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending     <= due_results.size();
        o_window_base <= window_base;
        o_seq_next    <= seq_next;
    end

endmodule

[verif/testbench.sv]
// Testbench top for the go-back-n sender window: clock, reset, stimulus, receiver and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gbn_pkg::*;

    localparam logic [1:0] OP_RESERVED     = 2'd3;
    localparam int         HOLD_CYCLES     = 150;
    localparam int         SETTLE_CYCLES   = 40;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         ITEMS_PER_PHASE = 24;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_cfg_wr_en      = 1'b0;
    logic [SEQ_W-1:0]  i_cfg_wr_data    = '0;
    logic              i_valid          = 1'b0;
    logic              o_stall;
    logic [1:0]        i_operation      = '0;
    logic [LEN_W-1:0]  i_payload_length = '0;
    logic              i_at_end         = 1'b0;
    logic [SEQ_W-1:0]  i_ack_number     = '0;
    logic [SEQ_W-1:0]  i_ack_connection = '0;
    logic              i_ack_flag_set   = 1'b0;
    logic              i_checksum_good  = 1'b0;
    logic              o_valid;
    logic              i_stall          = 1'b0;
    logic [2:0]        o_kind;
    logic [SEQ_W-1:0]  o_seq_number;
    logic [SLOT_W-1:0] o_slot;
    logic [LEN_W-1:0]  o_packet_length;
    logic              o_last;
    logic              o_finished_flag;

    logic              hold_toggle = 1'b0;
    logic              rx_steady   = 1'b0;
    bit                tx_steady   = 1'b0;
    logic [SEQ_W-1:0]  active_conn = '0;
    int                fail_count;
    int                pending;
    logic [SEQ_W-1:0]  win_base;
    logic [SEQ_W-1:0]  win_next;
    int                cycle_count = 0;

    go_back_n_sender_window i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_payload_length (i_payload_length),
        .i_at_end         (i_at_end),
        .i_ack_number     (i_ack_number),
        .i_ack_connection (i_ack_connection),
        .i_ack_flag_set   (i_ack_flag_set),
        .i_checksum_good  (i_checksum_good),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_seq_number     (o_seq_number),
        .o_slot           (o_slot),
        .o_packet_length  (o_packet_length),
        .o_last           (o_last),
        .o_finished_flag  (o_finished_flag)
    );

    go_back_n_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_operation      (i_operation),
        .i_payload_length (i_payload_length),
        .i_at_end         (i_at_end),
        .i_ack_number     (i_ack_number),
        .i_ack_connection (i_ack_connection),
        .i_ack_flag_set   (i_ack_flag_set),
        .i_checksum_good  (i_checksum_good),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_kind           (o_kind),
        .i_seq_number     (o_seq_number),
        .i_slot           (o_slot),
        .i_packet_length  (o_packet_length),
        .i_last           (o_last),
        .i_finished_flag  (o_finished_flag),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_window_base    (win_base),
        .o_seq_next       (win_next)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin : receiver
        int   hold_left;
        logic seen_toggle;
        hold_left   = 0;
        seen_toggle = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rx_steady) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 34);
            end
        end
    end

    task automatic offer(input logic [1:0] op, input logic [LEN_W-1:0] len,
                         input logic at_end, input logic [SEQ_W-1:0] ack, conn,
                         input logic flag, good);
        while (!tx_steady && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= op;
        i_payload_length <= len;
        i_at_end         <= at_end;
        i_ack_number     <= ack;
        i_ack_connection <= conn;
        i_ack_flag_set   <= flag;
        i_checksum_good  <= good;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_connection(input logic [SEQ_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        active_conn    = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        int               issued;
        int               pick;
        int               sel;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] ack;
        logic [SEQ_W-1:0] conn;
        logic             flag;
        logic             good;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_connection(32'h0000_0000);

        // empty window, reserved op, sizes at both ends, every ack rejection
        offer(OP_TIMEOUT, '0, 1'b0, '0, '0, 1'b0, 1'b0);
        offer(OP_RESERVED, 11'h7FF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        offer(OP_SEND, 11'd0, 1'b0, '0, '0, 1'b0, 1'b0);
        offer(OP_SEND, 11'd1, 1'b1, '0, '0, 1'b0, 1'b0);
        offer(OP_SEND, LEN_W'(MAX_PAYLOAD), 1'b0, '0, '0, 1'b0, 1'b0);
        offer(OP_SEND, LEN_W'(MAX_PAYLOAD + 1), 1'b0, '0, '0, 1'b0, 1'b0);
        offer(OP_SEND, 11'h7FF, 1'b0, '0, '0, 1'b0, 1'b0);
        offer(OP_TIMEOUT, '0, 1'b0, '0, '0, 1'b0, 1'b0);
        offer(OP_ACK, '0, 1'b0, 32'd0, 32'd0, 1'b1, 1'b0);
        offer(OP_ACK, '0, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
        offer(OP_ACK, '0, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1);
        offer(OP_ACK, '0, 1'b0, 32'd5, 32'd0, 1'b1, 1'b1);
        offer(OP_ACK, '0, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1);
        offer(OP_ACK, '0, 1'b0, 32'd1, 32'd0, 1'b1, 1'b1);
        offer(OP_ACK, '0, 1'b0, 32'd0, 32'd0, 1'b1, 1'b1);
        offer(OP_SEND, 11'd0, 1'b1, '0, '0, 1'b0, 1'b0);
        offer(OP_SEND, 11'd7, 1'b0, '0, '0, 1'b0, 1'b0);
        offer(OP_TIMEOUT, '0, 1'b0, '0, '0, 1'b0, 1'b0);
        offer(OP_ACK, '0, 1'b0, 32'd5, 32'd0, 1'b1, 1'b1);
        offer(OP_TIMEOUT, '0, 1'b0, '0, '0, 1'b0, 1'b0);
        offer(OP_SEND, 11'd100, 1'b0, '0, '0, 1'b0, 1'b0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_connection(32'hFFFF_FFFF);
                1: write_connection($urandom);
                2: write_connection(32'h0000_0000);
                default: write_connection(32'hA5A5_5A5A);
            endcase
            if (phase == 1) begin
                hold_toggle <= ~hold_toggle;
            end
            rx_steady <= (phase == 2);
            tx_steady  = (phase == 2);
            issued = 0;
            while (issued < ITEMS_PER_PHASE) begin
                pick = (phase == 0 && issued == 0) ? 0 : $urandom_range(99);
                if (pick < 4) begin
                    // fill the window past full, then retransmit all of it
                    repeat (WINDOW_DEPTH + 2) begin
                        offer(OP_SEND, LEN_W'($urandom_range(1, MAX_PAYLOAD)), 1'b0,
                              $urandom, $urandom, 1'($urandom), 1'($urandom));
                    end
                    offer(OP_TIMEOUT, LEN_W'($urandom), 1'($urandom), $urandom, $urandom,
                          1'($urandom), 1'($urandom));
                    issued += WINDOW_DEPTH + 3;
                end else if (pick < 7) begin
                    offer(OP_RESERVED, LEN_W'($urandom), 1'($urandom), $urandom, $urandom,
                          1'($urandom), 1'($urandom));
                    issued++;
                end else if (pick < 49) begin
                    sel = $urandom_range(9);
                    if (sel == 0) begin
                        len = '0;
                    end else if (sel == 1) begin
                        len = LEN_W'($urandom_range(MAX_PAYLOAD + 1, 2047));
                    end else if (sel == 2) begin
                        len = LEN_W'($urandom);
                    end else begin
                        len = LEN_W'($urandom_range(1, MAX_PAYLOAD));
                    end
                    offer(OP_SEND, len, ($urandom_range(3) == 0), $urandom, $urandom,
                          1'($urandom), 1'($urandom));
                    issued++;
                end else if (pick < 83) begin
                    ack  = (win_next > win_base) ? win_base + $urandom_range(win_next - win_base - 1)
                                                 : win_base;
                    conn = active_conn;
                    flag = 1'b1;
                    good = 1'b1;
                    if ($urandom_range(4) == 0) begin
                        case ($urandom_range(5))
                            0: good = 1'b0;
                            1: conn = active_conn ^ ($urandom | 32'd1);
                            2: flag = 1'b0;
                            3: ack = $urandom;
                            4: ack = win_next;
                            default: ack = win_base - 1'b1 - $urandom_range(7);
                        endcase
                    end
                    offer(OP_ACK, LEN_W'($urandom), 1'($urandom), ack, conn, flag, good);
                    issued++;
                end else begin
                    offer(OP_TIMEOUT, LEN_W'($urandom), 1'($urandom), $urandom, $urandom,
                          1'($urandom), 1'($urandom));
                    issued++;
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
src/gbn_pkg.sv
src/gbn_ram.sv
src/gbn_front.sv
src/gbn_fifo.sv
src/gbn_back.sv
src/go_back_n_sender_window.sv
verif/go_back_n_checker.sv
verif/testbench.sv
